@@ design/apbm_pkg.sv @@
// shared types, constants and helpers for the ayuv blend pipeline
package apbm_pkg;

	localparam int unsigned GA_W   = 9;
	localparam int unsigned MODE_W = 4;
	localparam int unsigned CFG_W  = 9;
	localparam int unsigned IDX_W  = 1;

	localparam logic [IDX_W-1:0] REG_GLOBAL_ALPHA = 1'd0;
	localparam logic [IDX_W-1:0] REG_BLEND_MODE   = 1'd1;

	localparam logic [GA_W-1:0] GA_FULL = 9'd256;

	typedef enum logic [MODE_W-1:0] {
		MODE_NORMAL     = 4'd0,
		MODE_ADD        = 4'd1,
		MODE_SUBTRACT   = 4'd2,
		MODE_DARKEN     = 4'd3,
		MODE_LIGHTEN    = 4'd4,
		MODE_MULTIPLY   = 4'd5,
		MODE_DIFFERENCE = 4'd6,
		MODE_EXCLUSION  = 4'd7,
		MODE_SOFTLIGHT  = 4'd8,
		MODE_HARDLIGHT  = 4'd9
	} mode_t;

	typedef struct packed {
		logic [7:0] src_opacity;
		logic [7:0] src_luma;
		logic [7:0] src_cb;
		logic [7:0] src_cr;
		logic [7:0] dst_luma;
		logic [7:0] dst_cb;
		logic [7:0] dst_cr;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_opacity;
		logic [7:0] out_luma;
		logic [7:0] out_cb;
		logic [7:0] out_cr;
	} pix_out_t;

	// pipeline stall control between the stage block and the top level
	typedef struct packed {
		logic adv;
		logic out_free;
	} pipe_ctl_t;

	function automatic logic signed [19:0] clamp8(input logic signed [19:0] x);
		if (x < 0)
			return 20'sd0;
		else if (x > 255)
			return 20'sd255;
		else
			return x;
	endfunction

endpackage

@@ design/apbm_if.sv @@
// valid/ready channel carrying one pixel transaction
interface apbm_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/apbm_cfg.sv @@
// configuration registers: global alpha and blend mode
module apbm_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [apbm_pkg::IDX_W-1:0]  cfg_index,
	input  logic [apbm_pkg::CFG_W-1:0]  cfg_data,
	output logic [apbm_pkg::GA_W-1:0]   global_alpha,
	output logic [apbm_pkg::MODE_W-1:0] mode_sel
);
	import apbm_pkg::*;

	logic [GA_W-1:0]   ga_q;
	logic [MODE_W-1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ga_q   <= GA_FULL;
			mode_q <= MODE_NORMAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GLOBAL_ALPHA: ga_q <= (cfg_data > GA_FULL) ? GA_FULL : cfg_data;
				REG_BLEND_MODE:   mode_q <= cfg_data[MODE_W-1:0];
				default:          ;
			endcase
		end
	end

	assign global_alpha = ga_q;
	assign mode_sel     = mode_q;

`ifndef SYNTH
	a_ga_range: assert property (@(posedge clk) disable iff (!arst_n) ga_q <= GA_FULL)
		else $error("global alpha above full scale");
	a_ga_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == REG_GLOBAL_ALPHA && cfg_data <= GA_FULL
		|=> ga_q == $past(cfg_data))
		else $error("global alpha write lost");
	a_mode_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> $stable(mode_q))
		else $error("blend mode changed without write");
`endif
endmodule

@@ design/apbm_core.sv @@
// four-stage blend datapath: alpha, products, mix/shift, pull and pack
module apbm_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  apbm_pkg::pipe_ctl_t         ctl,
	input  logic                        in_valid,
	input  apbm_pkg::pix_in_t           in_pix,
	input  logic [apbm_pkg::GA_W-1:0]   global_alpha,
	input  logic [apbm_pkg::MODE_W-1:0] mode_sel,
	output logic                        out_valid,
	output apbm_pkg::pix_out_t          out_pix
);
	import apbm_pkg::*;

	// stage 1: effective alpha, per-mode operand preparation
	logic               v_s1;
	logic [8:0]         a_s1;
	mode_t              mode_s1;
	logic               keep_s1;
	logic signed [19:0] d_s1 [3];
	logic signed [19:0] x_s1 [3];
	logic [7:0]         sy_s1;
	logic [7:0]         s_s1 [3];

	mode_t              mode_c;
	logic [16:0]        aprod_c;
	logic signed [19:0] d_c [3];
	logic signed [19:0] s_c [3];
	logic signed [19:0] x_c [3];
	logic [7:0]         dd_c [3];
	logic [7:0]         ss_c [3];
	logic [7:0]         sy_c;

	always_comb begin
		aprod_c = {9'd0, in_pix.src_opacity} * {8'd0, global_alpha};
		mode_c  = (mode_sel > MODE_HARDLIGHT) ? MODE_NORMAL : mode_t'(mode_sel);
		dd_c[0] = in_pix.dst_luma;
		dd_c[1] = in_pix.dst_cb;
		dd_c[2] = in_pix.dst_cr;
		ss_c[0] = in_pix.src_luma;
		ss_c[1] = in_pix.src_cb;
		ss_c[2] = in_pix.src_cr;
		sy_c    = in_pix.src_luma;
		for (int i = 0; i < 3; i++) begin
			d_c[i] = {12'd0, dd_c[i]};
			s_c[i] = {12'd0, ss_c[i]};
			unique case (mode_c)
				MODE_DIFFERENCE:
					x_c[i] = ((d_c[i] > s_c[i]) ? d_c[i] - s_c[i] : s_c[i] - d_c[i]) + 20'sd127;
				MODE_EXCLUSION:
					x_c[i] = s_c[i];
				MODE_SOFTLIGHT:
					x_c[i] = d_c[i] + s_c[i] - 20'sd127;
				MODE_HARDLIGHT:
					x_c[i] = (i == 0) ? d_c[i] + (s_c[i] <<< 1) - 20'sd255
					                  : d_c[i] + s_c[i] - 20'sd127;
				default:
					x_c[i] = s_c[i];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (ctl.adv)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			a_s1    <= aprod_c[16:8];
			mode_s1 <= mode_c;
			keep_s1 <= (mode_c == MODE_DARKEN && in_pix.dst_luma < in_pix.src_luma) ||
			           (mode_c == MODE_LIGHTEN && in_pix.dst_luma > in_pix.src_luma);
			sy_s1   <= sy_c;
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= d_c[i];
				x_s1[i] <= x_c[i];
				s_s1[i] <= ss_c[i];
			end
		end
	end

	// stage 2: products; exclusion operand needs its own product first
	logic               v_s2;
	logic [8:0]         a_s2;
	mode_t              mode_s2;
	logic               keep_s2;
	logic signed [19:0] d_s2 [3];
	logic signed [19:0] x_s2 [3];
	logic signed [19:0] p_s2 [3];  // s*a per channel, luma one also feeds add/sub/multiply
	logic signed [19:0] q_s2 [3];  // multiply mode helper
	logic signed [19:0] x2_c [3];
	logic signed [19:0] p_c [3];
	logic signed [19:0] q_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (mode_s1 == MODE_EXCLUSION)
				x2_c[i] = ($signed({12'd0, ~d_s1[i][7:0]}) * $signed({12'd0, sy_s1}) +
				           $signed({12'd0, ~sy_s1}) * d_s1[i]) >>> 8;
			else
				x2_c[i] = x_s1[i];
			p_c[i] = $signed({11'd0, a_s1}) * $signed({12'd0, s_s1[i]});
			// du*sy + 128*(256-sy)
			q_c[i] = d_s1[i] * $signed({12'd0, sy_s1}) +
			         20'sd128 * (20'sd256 - $signed({12'd0, sy_s1}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (ctl.adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			a_s2    <= a_s1;
			mode_s2 <= mode_s1;
			keep_s2 <= keep_s1;
			for (int i = 0; i < 3; i++) begin
				d_s2[i] <= d_s1[i];
				x_s2[i] <= x2_c[i];
				p_s2[i] <= p_c[i];
				q_s2[i] <= q_c[i];
			end
		end
	end

	// stage 3: mix and mode results before pulls
	logic               v_s3;
	mode_t              mode_s3;
	logic signed [19:0] r_s3 [3];
	logic signed [19:0] r_c [3];
	logic signed [19:0] ia2;
	logic signed [31:0] m_c [3];
	logic signed [31:0] mx_c [3];

	always_comb begin
		ia2 = 20'sd255 - $signed({11'd0, a_s2});
		for (int i = 0; i < 3; i++) begin
			mx_c[i] = (32'(d_s2[i]) * 32'(ia2) + 32'(x_s2[i]) * $signed({23'd0, a_s2})) >>> 8;
			if (i == 0)
				m_c[i] = (32'(d_s2[i]) * (32'sd256 * 32'(ia2) + 32'(p_s2[0]))) >>> 16;
			else
				m_c[i] = (32'(d_s2[i]) * 32'(ia2) * 32'sd256 +
				          $signed({23'd0, a_s2}) * 32'(q_s2[i])) >>> 16;
			unique case (mode_s2)
				MODE_ADD, MODE_SUBTRACT: begin
					if (i == 0)
						r_c[i] = (mode_s2 == MODE_ADD) ? d_s2[0] + (p_s2[0] >>> 8)
						                               : d_s2[0] - (p_s2[0] >>> 8);
					else
						r_c[i] = d_s2[i] + ((20'sd127 * ia2 + p_s2[i]) >>> 8) - 20'sd127;
				end
				MODE_MULTIPLY: r_c[i] = m_c[i][19:0];
				MODE_DARKEN, MODE_LIGHTEN:
					r_c[i] = keep_s2 ? d_s2[i] : mx_c[i][19:0];
				default: r_c[i] = mx_c[i][19:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (ctl.adv)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			mode_s3 <= mode_s2;
			for (int i = 0; i < 3; i++)
				r_s3[i] <= r_c[i];
		end
	end

	// stage 4: luma pulls, chroma clamps, pack into the output register
	logic               hi_c, lo_c, pull_hi, pull_lo;
	logic signed [19:0] m_hi, m_lo;
	logic signed [19:0] y_c, u_c, v_c;
	logic               v_s4;
	pix_out_t           pix_s4;

	always_comb begin
		hi_c = (mode_s3 == MODE_ADD) || (mode_s3 == MODE_DIFFERENCE) ||
		       (mode_s3 == MODE_EXCLUSION) || (mode_s3 == MODE_SOFTLIGHT) ||
		       (mode_s3 == MODE_HARDLIGHT);
		lo_c = (mode_s3 == MODE_SUBTRACT) || (mode_s3 == MODE_DIFFERENCE) ||
		       (mode_s3 == MODE_EXCLUSION) || (mode_s3 == MODE_SOFTLIGHT) ||
		       (mode_s3 == MODE_HARDLIGHT);
		pull_hi = hi_c && (r_s3[0] > 20'sd255);
		pull_lo = !pull_hi && lo_c && (r_s3[0] < 0);
		m_hi = (r_s3[0] > 20'sd288) ? 20'sd0 : 20'sd288 - r_s3[0];
		m_lo = (r_s3[0] < -20'sd32) ? 20'sd32 : -r_s3[0];
		y_c = r_s3[0];
		u_c = r_s3[1];
		v_c = r_s3[2];
		if (pull_hi) begin
			u_c = (r_s3[1] * m_hi + 20'sd127 * (20'sd32 - m_hi)) >>> 5;
			v_c = (r_s3[2] * m_hi + 20'sd127 * (20'sd32 - m_hi)) >>> 5;
			y_c = 20'sd255;
		end else if (pull_lo) begin
			u_c = (r_s3[1] * (20'sd32 - m_lo) + 20'sd127 * m_lo) >>> 5;
			v_c = (r_s3[2] * (20'sd32 - m_lo) + 20'sd127 * m_lo) >>> 5;
			y_c = 20'sd0;
		end
		if (mode_s3 == MODE_ADD) begin
			if (u_c > 20'sd255) u_c = 20'sd255;
			if (v_c > 20'sd255) v_c = 20'sd255;
		end else if (mode_s3 == MODE_DIFFERENCE || mode_s3 == MODE_EXCLUSION) begin
			u_c = clamp8(u_c);
			v_c = clamp8(v_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (ctl.adv)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			pix_s4.out_opacity <= 8'hff;
			pix_s4.out_luma    <= y_c[7:0];
			pix_s4.out_cb      <= u_c[7:0];
			pix_s4.out_cr      <= v_c[7:0];
		end
	end

	assign out_valid = v_s4;
	assign out_pix   = pix_s4;

`ifndef SYNTH
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.adv |=> $stable(v_s4) && $stable(pix_s4))
		else $error("output stage changed during stall");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.adv && v_s3 |=> v_s4)
		else $error("transaction dropped between stages");
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> a_s1 <= 9'd256)
		else $error("effective alpha out of range");
`endif
endmodule

@@ design/ayuv_pixel_blend_modes.sv @@
// AYUV pixel blender with ten blend modes, top level
//
// Usage: source and destination bytes of one pixel arrive as one transaction
// on the in channel (valid/ready); the blended pixel leaves on the out channel.
// Global alpha (index 0) and blend mode (index 1) are written through the
// cfg_we/cfg_index/cfg_data port while no transaction is in flight.
// out.valid is driven by the last stage register, so an accepted pixel passes
// through every stage register before its result can be taken.
// Throughput: one pixel per clock unless stalled; four register stages
// (alpha and operands, products, mix, pull and pack) all move together.
// A stall at the output freezes every stage and holds in.ready low only while
// the output register is full and not taken, so nothing is lost or repeated.
// Reset (arst_n low) empties the pipeline, sets global alpha to 256 and the
// blend mode to normal.
// Output alpha is always 255.
module ayuv_pixel_blend_modes (
	input  logic                       clk,
	input  logic                       arst_n,
	apbm_if.sink                       in,
	apbm_if.source                     out,
	input  logic                       cfg_we,
	input  logic [apbm_pkg::IDX_W-1:0] cfg_index,
	input  logic [apbm_pkg::CFG_W-1:0] cfg_data
);
	import apbm_pkg::*;

	logic [GA_W-1:0]   ga;
	logic [MODE_W-1:0] mode;
	pipe_ctl_t         ctl;
	logic              ov;

	apbm_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.global_alpha (ga),
		.mode_sel     (mode)
	);

	assign ctl.out_free = !ov || out.ready;
	assign ctl.adv      = ctl.out_free;
	assign in.ready     = ctl.adv;
	assign out.valid    = ov;

	apbm_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.in_valid     (in.valid),
		.in_pix       (in.data),
		.global_alpha (ga),
		.mode_sel     (mode),
		.out_valid    (ov),
		.out_pix      (out.data)
	);

`ifndef SYNTH
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!ov |-> in.ready)
		else $error("input stalled with empty output");
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		ov && !out.ready |=> ov)
		else $error("pending transaction vanished");
	a_alpha_out: assert property (@(posedge clk) disable iff (!arst_n)
		ov |-> out.data.out_opacity == 8'hff)
		else $error("output alpha not opaque");
`endif
endmodule
